// File: rtl/core/ltsp_pkg.sv
// ----------------------------------------------------------------------------
// Legacy transaction stream parser package
// Beat types, parse phases, error codes and the constants of the compact-size
// encoding shared by the front end, the queue and the parsing engine.
// ----------------------------------------------------------------------------
package ltsp_pkg;

   localparam int unsigned HASH_BYTES = 32;

   localparam logic [7:0]  PFX_TWO  = 8'hFD;
   localparam logic [7:0]  PFX_FOUR = 8'hFE;
   localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;

   localparam logic [3:0] KIND_ERROR = 4'd12;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_TRUNC = 2'd1;
   localparam logic [1:0] ERR_TRAIL = 2'd2;
   localparam logic [1:0] ERR_LARGE = 2'd3;

   typedef enum logic [3:0] {
      PH_VERSION  = 4'd0,
      PH_INCOUNT  = 4'd1,
      PH_HASH     = 4'd2,
      PH_OUTIDX   = 4'd3,
      PH_SIGLEN   = 4'd4,
      PH_SIGBYTE  = 4'd5,
      PH_SEQ      = 4'd6,
      PH_OUTCOUNT = 4'd7,
      PH_AMOUNT   = 4'd8,
      PH_PKLEN    = 4'd9,
      PH_PKBYTE   = 4'd10,
      PH_LOCK     = 4'd11,
      PH_DONE     = 4'd12
   } phase_type;

   typedef enum logic [1:0] {
      VS_DIRECT = 2'd0,
      VS_TWO    = 2'd1,
      VS_FOUR   = 2'd2,
      VS_EIGHT  = 2'd3
   } vsize_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [3:0]  field_kind;
      logic [63:0] field_value;
      logic [31:0] entry_index;
      logic [31:0] byte_index;
      logic        frame_end;
      logic        frame_ok;
      logic [1:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      vsize_type  vsize;
   } item_type;

endpackage

// File: rtl/core/ltsp_front.sv
// ----------------------------------------------------------------------------
// Legacy transaction stream parser front end
// Accepts request beats while the queue has room and classifies each byte by
// the compact-size prefix it would form.
// ----------------------------------------------------------------------------
module ltsp_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  ltsp_pkg::req_type req_payload,
   input  logic              queue_full,
   output logic              push,
   output ltsp_pkg::item_type push_item
);
   import ltsp_pkg::*;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.data = req_payload.in_byte;
      push_item.last = req_payload.frame_last;
      priority if (req_payload.in_byte < PFX_TWO) begin
         push_item.vsize = VS_DIRECT;
      end else if (req_payload.in_byte == PFX_TWO) begin
         push_item.vsize = VS_TWO;
      end else if (req_payload.in_byte == PFX_FOUR) begin
         push_item.vsize = VS_FOUR;
      end else begin
         push_item.vsize = VS_EIGHT;
      end
   end

endmodule

// File: rtl/core/ltsp_queue.sv
// ----------------------------------------------------------------------------
// Legacy transaction stream parser queue
// A short first-in first-out queue of classified beats between the front end
// and the parsing engine.
// ----------------------------------------------------------------------------
module ltsp_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ltsp_pkg::item_type push_item,
   output logic               full,
   output logic               head_valid,
   output ltsp_pkg::item_type head_item,
   input  logic               pop
);
   import ltsp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type              entries_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue holds more beats than its depth");
   a_pointers_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("beat pushed into a full queue");
`endif

endmodule

// File: rtl/core/ltsp_back.sv
// ----------------------------------------------------------------------------
// Legacy transaction stream parser engine
// Takes classified beats from the queue, steps the transaction parse state
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module ltsp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  ltsp_pkg::item_type head_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ltsp_pkg::rsp_type  rsp_payload
);
   import ltsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  fbc_ff, fbc_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  vleft_ff, vleft_in;
   logic [31:0] eleft_ff, eleft_in;
   logic [31:0] ecnt_ff, ecnt_in;
   logic [31:0] sleft_ff, sleft_in;
   logic [31:0] scnt_ff, scnt_in;
   logic [1:0]  perr_ff, perr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [63:0] acc_sh;
   logic [3:0]  fbc_inc;
   logic        fix_done;
   logic        v_done, v_large;
   logic [31:0] v_val;
   logic [63:0] v_acc;
   logic [3:0]  v_fbc, v_left;
   logic        have;
   logic [63:0] val;
   logic [31:0] ei, bi;
   logic        flag_large, flag_trail;
   logic        emit;
   logic [1:0]  code;
   logic [31:0] eleft_dec, sleft_dec;

   assign acc_sh    = acc_ff | (64'(head_item.data) << {fbc_ff[2:0], 3'b000});
   assign fbc_inc   = fbc_ff + 4'd1;
   assign fix_done  = (phase_ff == PH_AMOUNT) ? (fbc_inc >= 4'd8) : (fbc_inc >= 4'd4);
   assign eleft_dec = eleft_ff - 32'd1;
   assign sleft_dec = sleft_ff - 32'd1;

   // Compact-size step: a prefix byte either is the value or sets the length.
   always_comb begin
      v_done  = 1'b0;
      v_large = 1'b0;
      v_val   = {24'd0, head_item.data};
      v_acc   = acc_ff;
      v_fbc   = fbc_ff;
      v_left  = vleft_ff;
      if (vleft_ff == 4'd0) begin
         v_acc = '0;
         v_fbc = '0;
         unique case (head_item.vsize)
            VS_DIRECT: begin
               v_done = 1'b1;
               v_acc  = acc_ff;
               v_fbc  = fbc_ff;
            end
            VS_TWO:   v_left = 4'd2;
            VS_FOUR:  v_left = 4'd4;
            VS_EIGHT: v_left = 4'd8;
         endcase
      end else begin
         v_acc  = acc_sh;
         v_fbc  = fbc_inc;
         v_left = vleft_ff - 4'd1;
         if (v_left == 4'd0) begin
            v_done = 1'b1;
            v_acc  = '0;
            v_fbc  = '0;
            if (acc_sh[63:32] != 32'd0) begin
               v_val   = MAX32;
               v_large = 1'b1;
            end else begin
               v_val = acc_sh[31:0];
            end
         end
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      fbc_in     = fbc_ff;
      acc_in     = acc_ff;
      vleft_in   = vleft_ff;
      eleft_in   = eleft_ff;
      ecnt_in    = ecnt_ff;
      sleft_in   = sleft_ff;
      scnt_in    = scnt_ff;
      have       = 1'b0;
      val        = '0;
      ei         = '0;
      bi         = '0;
      flag_large = 1'b0;
      flag_trail = 1'b0;
      unique case (phase_ff)
         PH_VERSION, PH_OUTIDX, PH_SEQ, PH_AMOUNT, PH_LOCK: begin
            if (phase_ff != PH_VERSION && phase_ff != PH_LOCK) begin
               ei = ecnt_ff;
            end
            val    = acc_sh;
            have   = fix_done;
            acc_in = fix_done ? '0 : acc_sh;
            fbc_in = fix_done ? '0 : fbc_inc;
            if (fix_done) begin
               unique case (phase_ff)
                  PH_VERSION: phase_in = PH_INCOUNT;
                  PH_OUTIDX:  phase_in = PH_SIGLEN;
                  PH_AMOUNT:  phase_in = PH_PKLEN;
                  PH_LOCK:    phase_in = PH_DONE;
                  default: begin
                     ecnt_in  = ecnt_ff + 32'd1;
                     eleft_in = eleft_dec;
                     scnt_in  = '0;
                     phase_in = (eleft_dec == 32'd0) ? PH_OUTCOUNT : PH_HASH;
                  end
               endcase
            end
         end
         PH_INCOUNT, PH_OUTCOUNT, PH_SIGLEN, PH_PKLEN: begin
            if (phase_ff == PH_SIGLEN || phase_ff == PH_PKLEN) begin
               ei = ecnt_ff;
            end
            acc_in     = v_acc;
            fbc_in     = v_fbc;
            vleft_in   = v_left;
            have       = v_done;
            val        = {32'd0, v_val};
            flag_large = v_large;
            if (v_done) begin
               scnt_in = '0;
               unique case (phase_ff)
                  PH_INCOUNT: begin
                     eleft_in = v_val;
                     ecnt_in  = '0;
                     phase_in = (v_val == 32'd0) ? PH_OUTCOUNT : PH_HASH;
                  end
                  PH_OUTCOUNT: begin
                     eleft_in = v_val;
                     ecnt_in  = '0;
                     phase_in = (v_val == 32'd0) ? PH_LOCK : PH_AMOUNT;
                  end
                  PH_SIGLEN: begin
                     sleft_in = v_val;
                     phase_in = (v_val == 32'd0) ? PH_SEQ : PH_SIGBYTE;
                  end
                  default: begin
                     sleft_in = v_val;
                     if (v_val == 32'd0) begin
                        ecnt_in  = ecnt_ff + 32'd1;
                        eleft_in = eleft_dec;
                        phase_in = (eleft_dec == 32'd0) ? PH_LOCK : PH_AMOUNT;
                     end else begin
                        phase_in = PH_PKBYTE;
                     end
                  end
               endcase
            end
         end
         PH_HASH: begin
            have = 1'b1;
            val  = {56'd0, head_item.data};
            ei   = ecnt_ff;
            bi   = scnt_ff;
            if (scnt_ff >= 32'(HASH_BYTES - 1)) begin
               scnt_in  = '0;
               phase_in = PH_OUTIDX;
            end else begin
               scnt_in = scnt_ff + 32'd1;
            end
         end
         PH_SIGBYTE, PH_PKBYTE: begin
            have     = 1'b1;
            val      = {56'd0, head_item.data};
            ei       = ecnt_ff;
            bi       = scnt_ff;
            scnt_in  = scnt_ff + 32'd1;
            sleft_in = sleft_dec;
            if (sleft_dec == 32'd0) begin
               if (phase_ff == PH_SIGBYTE) begin
                  phase_in = PH_SEQ;
               end else begin
                  ecnt_in  = ecnt_ff + 32'd1;
                  eleft_in = eleft_dec;
                  scnt_in  = '0;
                  phase_in = (eleft_dec == 32'd0) ? PH_LOCK : PH_AMOUNT;
               end
            end
         end
         default: begin
            phase_in   = PH_DONE;
            flag_trail = 1'b1;
         end
      endcase

      perr_in = perr_ff;
      if (perr_ff == ERR_NONE) begin
         priority if (flag_large) begin
            perr_in = ERR_LARGE;
         end else if (flag_trail) begin
            perr_in = ERR_TRAIL;
         end
      end

      code = perr_in;
      if (code == ERR_NONE && phase_in != PH_DONE) begin
         code = ERR_TRUNC;
      end

      emit = have || head_item.last;

      rsp_in.field_kind  = have ? phase_ff : KIND_ERROR;
      rsp_in.field_value = have ? val : '0;
      rsp_in.entry_index = have ? ei : '0;
      rsp_in.byte_index  = have ? bi : '0;
      rsp_in.frame_end   = head_item.last;
      rsp_in.frame_ok    = head_item.last && (code == ERR_NONE);
      rsp_in.error_code  = head_item.last ? code : ERR_NONE;

      if (head_item.last) begin
         phase_in = PH_VERSION;
         fbc_in   = '0;
         acc_in   = '0;
         vleft_in = '0;
         eleft_in = '0;
         ecnt_in  = '0;
         sleft_in = '0;
         scnt_in  = '0;
         perr_in  = ERR_NONE;
      end
   end

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall || !emit);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VERSION;
         fbc_ff       <= '0;
         acc_ff       <= '0;
         vleft_ff     <= '0;
         eleft_ff     <= '0;
         ecnt_ff      <= '0;
         sleft_ff     <= '0;
         scnt_ff      <= '0;
         perr_ff      <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            fbc_ff   <= fbc_in;
            acc_ff   <= acc_in;
            vleft_ff <= vleft_in;
            eleft_ff <= eleft_in;
            ecnt_ff  <= ecnt_in;
            sleft_ff <= sleft_in;
            scnt_ff  <= scnt_in;
            perr_ff  <= perr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.frame_end) |->
         (!rsp_ff.frame_ok && rsp_ff.error_code == ERR_NONE))
      else $error("frame status given on a beat that does not end the frame");
   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_end) |->
         (rsp_ff.frame_ok == (rsp_ff.error_code == ERR_NONE)))
      else $error("frame ok disagrees with the error code");
   a_status_kind_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.field_kind == KIND_ERROR) |->
         (rsp_ff.frame_end && rsp_ff.field_value == '0))
      else $error("status-only result outside the end of a frame");
   a_restart_after_frame: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.last) |=> (phase_ff == PH_VERSION && perr_ff == ERR_NONE))
      else $error("parser did not restart after the end of a frame");
`endif

endmodule

// File: rtl/core/legacy_tx_stream_parser.sv
// ----------------------------------------------------------------------------
// Legacy transaction stream parser
// Parses an unsigned legacy transaction one byte per beat and reports each
// field, each hash and script byte, and the frame status on the last byte.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while the queue has room, and
// gives at most one result beat per byte. An accepted byte enters a queue of
// QUEUE_DEPTH beats; the parsing engine takes it from the head of the queue,
// steps its state machine and counters once for the byte and loads the
// output register, from which the result is taken. Bytes that complete no
// field and do not end the frame are absorbed even while a result waits to be
// taken; the input stalls only when the queue is full.
module legacy_tx_stream_parser #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ltsp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ltsp_pkg::rsp_type rsp_payload
);
   import ltsp_pkg::*;

   logic     queue_full;
   logic     push;
   item_type push_item;
   logic     head_valid;
   item_type head_item;
   logic     pop;

   ltsp_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item)
   );

   ltsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   ltsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: bench/tx_parse_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transaction field scoreboard
// Predicts the field beats that the legacy transaction parser gives for each
// accepted byte and checks every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
package tx_parse_check_pkg;

   import ltsp_pkg::*;

   class tx_field_scoreboard;

      phase_type   phase;
      logic [3:0]  fbytes;
      logic [63:0] acc;
      logic [3:0]  vleft;
      logic [31:0] entries_left;
      logic [31:0] entry_no;
      logic [31:0] script_left;
      logic [31:0] script_pos;
      logic [1:0]  err_seen;

      rsp_type     expected_q[$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned frames_ok;
      int unsigned frames_bad;

      function new();
         clear_frame();
         mismatches = 0;
         checked    = 0;
         frames_ok  = 0;
         frames_bad = 0;
      endfunction

      function void clear_frame();
         phase        = PH_VERSION;
         fbytes       = '0;
         acc          = '0;
         vleft        = '0;
         entries_left = '0;
         entry_no     = '0;
         script_left  = '0;
         script_pos   = '0;
         err_seen     = ERR_NONE;
      endfunction

      function void note_error(logic [1:0] code);
         if (err_seen == ERR_NONE) begin
            err_seen = code;
         end
      endfunction

      function bit take_fixed(logic [7:0] b, int unsigned n, output logic [63:0] v);
         acc    = acc | (64'(b) << (8 * fbytes[2:0]));
         fbytes = fbytes + 4'd1;
         v      = acc;
         if (fbytes >= n) begin
            acc    = '0;
            fbytes = '0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function bit take_compact(logic [7:0] b, output logic [63:0] v);
         v = {56'd0, b};
         if (vleft == 4'd0) begin
            if (b < PFX_TWO) begin
               return 1'b1;
            end
            vleft  = (b == PFX_TWO) ? 4'd2 : (b == PFX_FOUR) ? 4'd4 : 4'd8;
            acc    = '0;
            fbytes = '0;
            return 1'b0;
         end
         acc    = acc | (64'(b) << (8 * fbytes[2:0]));
         fbytes = fbytes + 4'd1;
         vleft  = vleft - 4'd1;
         if (vleft != 4'd0) begin
            return 1'b0;
         end
         v      = acc;
         acc    = '0;
         fbytes = '0;
         if (v > 64'(MAX32)) begin
            v = 64'(MAX32);
            note_error(ERR_LARGE);
         end
         return 1'b1;
      endfunction

      function void next_entry(phase_type more, phase_type after);
         entry_no     = entry_no + 32'd1;
         entries_left = entries_left - 32'd1;
         script_pos   = '0;
         phase        = (entries_left == 32'd0) ? after : more;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_byte(req_type beat);
         logic [7:0]  b;
         logic        have;
         logic [63:0] v;
         logic [1:0]  code;
         rsp_type     r;
         b            = beat.in_byte;
         have         = 1'b0;
         v            = '0;
         r            = '0;
         r.field_kind = phase;
         case (phase)
            PH_VERSION: begin
               if (take_fixed(b, 4, v)) begin
                  have  = 1'b1;
                  phase = PH_INCOUNT;
               end
            end
            PH_INCOUNT: begin
               if (take_compact(b, v)) begin
                  have         = 1'b1;
                  entries_left = v[31:0];
                  entry_no     = '0;
                  script_pos   = '0;
                  phase        = (v[31:0] == 32'd0) ? PH_OUTCOUNT : PH_HASH;
               end
            end
            PH_HASH: begin
               have          = 1'b1;
               v             = {56'd0, b};
               r.entry_index = entry_no;
               r.byte_index  = script_pos;
               script_pos    = script_pos + 32'd1;
               if (script_pos >= HASH_BYTES) begin
                  script_pos = '0;
                  phase      = PH_OUTIDX;
               end
            end
            PH_OUTIDX: begin
               r.entry_index = entry_no;
               if (take_fixed(b, 4, v)) begin
                  have  = 1'b1;
                  phase = PH_SIGLEN;
               end
            end
            PH_SIGLEN: begin
               r.entry_index = entry_no;
               if (take_compact(b, v)) begin
                  have        = 1'b1;
                  script_left = v[31:0];
                  script_pos  = '0;
                  phase       = (script_left == 32'd0) ? PH_SEQ : PH_SIGBYTE;
               end
            end
            PH_SIGBYTE: begin
               have          = 1'b1;
               v             = {56'd0, b};
               r.entry_index = entry_no;
               r.byte_index  = script_pos;
               script_pos    = script_pos + 32'd1;
               script_left   = script_left - 32'd1;
               if (script_left == 32'd0) begin
                  phase = PH_SEQ;
               end
            end
            PH_SEQ: begin
               r.entry_index = entry_no;
               if (take_fixed(b, 4, v)) begin
                  have = 1'b1;
                  next_entry(PH_HASH, PH_OUTCOUNT);
               end
            end
            PH_OUTCOUNT: begin
               if (take_compact(b, v)) begin
                  have         = 1'b1;
                  entries_left = v[31:0];
                  entry_no     = '0;
                  script_pos   = '0;
                  phase        = (v[31:0] == 32'd0) ? PH_LOCK : PH_AMOUNT;
               end
            end
            PH_AMOUNT: begin
               r.entry_index = entry_no;
               if (take_fixed(b, 8, v)) begin
                  have  = 1'b1;
                  phase = PH_PKLEN;
               end
            end
            PH_PKLEN: begin
               r.entry_index = entry_no;
               if (take_compact(b, v)) begin
                  have        = 1'b1;
                  script_left = v[31:0];
                  script_pos  = '0;
                  if (script_left == 32'd0) begin
                     next_entry(PH_AMOUNT, PH_LOCK);
                  end else begin
                     phase = PH_PKBYTE;
                  end
               end
            end
            PH_PKBYTE: begin
               have          = 1'b1;
               v             = {56'd0, b};
               r.entry_index = entry_no;
               r.byte_index  = script_pos;
               script_pos    = script_pos + 32'd1;
               script_left   = script_left - 32'd1;
               if (script_left == 32'd0) begin
                  next_entry(PH_AMOUNT, PH_LOCK);
               end
            end
            PH_LOCK: begin
               if (take_fixed(b, 4, v)) begin
                  have  = 1'b1;
                  phase = PH_DONE;
               end
            end
            default: begin
               phase = PH_DONE;
               note_error(ERR_TRAIL);
            end
         endcase

         if (!have && !beat.frame_last) begin
            return;
         end
         if (!have) begin
            r.field_kind  = KIND_ERROR;
            v             = '0;
            r.entry_index = '0;
            r.byte_index  = '0;
         end
         r.field_value = v;
         if (beat.frame_last) begin
            code = err_seen;
            if (code == ERR_NONE && phase != PH_DONE) begin
               code = ERR_TRUNC;
            end
            r.frame_end  = 1'b1;
            r.frame_ok   = (code == ERR_NONE);
            r.error_code = code;
            clear_frame();
         end
         expected_q = {expected_q, r};
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         mismatches++;
      endtask

      task check_field(rsp_type got);
         rsp_type e;
         string   bad;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d value %h",
                                      got.field_kind, got.field_value));
            return;
         end
         e   = expected_q.pop_front();
         bad = "";
         checked++;
         if (e.frame_end) begin
            if (e.frame_ok) frames_ok++;
            else frames_bad++;
         end
         if (got.field_kind !== e.field_kind) bad = {bad, " kind"};
         if (got.field_value !== e.field_value) bad = {bad, " value"};
         if (got.entry_index !== e.entry_index) bad = {bad, " entry"};
         if (got.byte_index !== e.byte_index) bad = {bad, " byte"};
         if (got.frame_end !== e.frame_end) bad = {bad, " end"};
         if (got.frame_ok !== e.frame_ok) bad = {bad, " ok"};
         if (got.error_code !== e.error_code) bad = {bad, " error"};
         if (bad != "") begin
            report_mismatch($sformatf(
               {"beat %0d wrong%s: exp %0d/%h/%0d/%0d/%b/%b/%0d",
                " got %0d/%h/%0d/%0d/%b/%b/%0d"},
               checked, bad, e.field_kind, e.field_value, e.entry_index, e.byte_index,
               e.frame_end, e.frame_ok, e.error_code, got.field_kind, got.field_value,
               got.entry_index, got.byte_index, got.frame_end, got.frame_ok,
               got.error_code));
         end
      endtask

   endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Legacy transaction parser testbench
// Streams directed and randomly built transactions, well formed and broken,
// into the parser under random sender gaps and receiver stalls, and checks
// every result beat against a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_top;

   import ltsp_pkg::*;
   import tx_parse_check_pkg::*;

   localparam logic [7:0] PFX_EIGHT   = 8'hFF;
   localparam int         HOLD_CYCLES = 120;
   localparam int         RANDOM_BYTES = 850;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   tx_field_scoreboard fields;

   logic [7:0]  frame_bytes[$];
   int unsigned bytes_sent;
   int unsigned frames_sent;
   int unsigned burst_left;
   int unsigned drain_pauses;
   bit          hold_done;

   legacy_tx_stream_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            fields.note_byte(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            fields.check_field(rsp_payload);
         end
      end
   end

   // The receiver follows its own stall pattern, with one long hold-off
   // once a good part of the stream has gone in.
   initial begin
      int unsigned mode;
      int unsigned seg_len;
      int unsigned n;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && bytes_sent >= 200) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode    = $urandom_range(0, 9);
         seg_len = $urandom_range(4, 40);
         for (n = 0; n < seg_len; n++) begin
            if (mode <= 2) rsp_stall <= 1'b0;
            else if (mode <= 5) rsp_stall <= 1'($urandom_range(0, 1));
            else if (mode <= 7) rsp_stall <= (n % 3 == 0);
            else if (mode == 8) rsp_stall <= ($urandom_range(0, 3) != 0);
            else rsp_stall <= 1'b1;
            @(negedge clock);
         end
      end
   end

   function automatic void add_byte(logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endfunction

   function automatic void add_le(logic [63:0] v, int n);
      for (int i = 0; i < n; i++) begin
         add_byte(v[8*i +: 8]);
      end
   endfunction

   function automatic void add_random(int n);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
   endfunction

   // Picks the short form where it fits, but often a wider one as well.
   function automatic void add_compact(logic [63:0] v);
      int unsigned form;
      form = $urandom_range(0, 3);
      if (v < {56'd0, PFX_TWO} && form != 0) begin
         add_byte(v[7:0]);
      end else if (v <= 64'hFFFF && form <= 1) begin
         add_byte(PFX_TWO);
         add_le(v, 2);
      end else if (v <= 64'(MAX32) && form <= 2) begin
         add_byte(PFX_FOUR);
         add_le(v, 4);
      end else begin
         add_byte(PFX_EIGHT);
         add_le(v, 8);
      end
   endfunction

   function automatic int script_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(200, 300);
      return $urandom_range(0, 5);
   endfunction

   function automatic void build_tx();
      int n_in;
      int n_out;
      int len;
      frame_bytes.delete();
      add_random(4);
      n_in = $urandom_range(0, 2);
      add_compact(64'(n_in));
      repeat (n_in) begin
         add_random(HASH_BYTES + 4);
         len = script_len();
         add_compact(64'(len));
         add_random(len + 4);
      end
      n_out = $urandom_range(0, 2);
      add_compact(64'(n_out));
      repeat (n_out) begin
         add_random(8);
         len = script_len();
         add_compact(64'(len));
         add_random(len);
      end
      add_random(4);
   endfunction

   task automatic put_byte(logic [7:0] b, logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_payload <= '{in_byte: b, frame_last: last};
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         put_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      frames_sent++;
   endtask

   task automatic idle_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (fields.pending() != 0) @(negedge clock);
      burst_left = 0;
      drain_pauses++;
   endtask

   initial begin
      int unsigned pick;
      int unsigned cut;
      int unsigned waited;
      fields       = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      bytes_sent   = 0;
      frames_sent  = 0;
      burst_left   = 0;
      drain_pauses = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Smallest complete transaction: no inputs, no outputs.
      frame_bytes.delete();
      add_le(64'd1, 4);
      add_byte(8'h00);
      add_byte(8'h00);
      add_le(64'd0, 4);
      send_frame();

      // A frame that ends on its first byte.
      frame_bytes.delete();
      add_byte(8'hFF);
      send_frame();

      // An input count beyond 32 bits, then the frame stops in the first hash.
      frame_bytes.delete();
      add_le(64'(MAX32), 4);
      add_byte(PFX_EIGHT);
      add_le('1, 8);
      add_byte(8'h00);
      send_frame();

      idle_until_drained();

      while (bytes_sent < 25 + RANDOM_BYTES) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            build_tx();
         end else if (pick < 15) begin
            build_tx();
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end else if (pick < 17) begin
            build_tx();
            add_random($urandom_range(1, 3));
         end else if (pick < 19) begin
            frame_bytes.delete();
            add_random($urandom_range(1, 12));
         end else begin
            frame_bytes.delete();
            add_random(4);
            add_byte(PFX_EIGHT);
            add_random(7);
            add_byte(8'($urandom_range(1, 255)));
            add_random($urandom_range(0, 5));
         end
         send_frame();
         if ((bytes_sent < 150 || hold_done) && $urandom_range(0, 7) == 0) begin
            idle_until_drained();
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      while (fields.pending() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(negedge clock);
      if (fields.pending() != 0) begin
         fields.report_mismatch($sformatf("%0d expected beats never arrived",
                                          fields.pending()));
      end

      $display("Sent %0d frames in %0d bytes; %0d result beats checked,",
               frames_sent, bytes_sent, fields.checked);
      $display("%0d frames ok, %0d with an error status; one %0d-cycle hold-off, %0d drains.",
               fields.frames_ok, fields.frames_bad, HOLD_CYCLES, drain_pauses);
      if (fields.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
